// File: sv/lmt_pkg.sv
// ----------------------------------------------------------------------------
// lmt_pkg
// Shared types, constants and character helpers for the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package lmt_pkg;

   localparam longint unsigned MAX_LENGTH = 65535;
   localparam logic [15:0] POS_LIMIT =
      (MAX_LENGTH < 65535) ? 16'(MAX_LENGTH) : 16'hFFFF;

   // matcher state code for a class that can no longer match
   localparam logic [3:0] DEAD    = 4'hF;
   localparam logic [3:0] NO_KIND = 4'hF;

   // class indexes, in priority order
   localparam logic [3:0] C_WS = 4'd0;
   localparam logic [3:0] C_CM = 4'd1;
   localparam logic [3:0] C_KW = 4'd2;
   localparam logic [3:0] C_US = 4'd3;
   localparam logic [3:0] C_SY = 4'd4;
   localparam logic [3:0] C_FL = 4'd5;
   localparam logic [3:0] C_IN = 4'd6;
   localparam logic [3:0] C_BO = 4'd7;
   localparam logic [3:0] C_ST = 4'd8;
   localparam logic [3:0] C_ID = 4'd9;

   localparam logic [3:0] KIND_END = 4'd8;

   // keyword and bool words, byte 0 in the low bits
   localparam logic [4:0][63:0] KW_TEXT = {
      64'h0000_0000_0064_6F6D,   // mod
      64'h0000_0000_6573_6C65,   // else
      64'h0000_0000_0000_6669,   // if
      64'h0000_0000_0000_6E66,   // fn
      64'h0000_0000_0074_656C    // let
   };
   localparam logic [4:0][2:0] KW_LEN = {3'd3, 3'd4, 3'd2, 3'd2, 3'd3};
   localparam logic [1:0][63:0] BO_TEXT = {
      64'h0000_0065_736C_6166,   // false
      64'h0000_0000_6575_7274    // true
   };
   localparam logic [1:0][2:0] BO_LEN = {3'd5, 3'd4};

   typedef struct packed {
      logic [7:0] char_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [15:0] token_start;
      logic [15:0] token_end;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic load;        // new byte from the input channel
      logic step;        // feed the queue head to the matchers
      logic fin_close;   // close pending token at end of text
      logic set_stop;
      logic emit_end;    // end transaction, then clear everything
   } cmd_type;

   typedef struct packed {
      logic stopped;
      logic at_limit;
      logic q_empty;
      logic dead_best;   // head byte kills every matcher and a best exists
      logic best_none;
      logic len_zero;
      logic out_free;
   } status_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_single(input logic [7:0] c);
      return (c == 8'h28) || (c == 8'h29) || (c == 8'h7B) || (c == 8'h7D) ||
             (c == 8'h2C) || (c == 8'h2E) || (c == 8'h26) || (c == 8'h3B);
   endfunction

endpackage

`default_nettype wire

// File: sv/lmt_datapath.sv
// ----------------------------------------------------------------------------
// lmt_datapath
// Class matchers, best-match tracking, replay queue and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lmt_datapath import lmt_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   input  wire req_type    req_data,
   output status_type      status,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data
);

   logic [3:0]  ws_ff, cm_ff, us_ff, sy_ff, fl_ff, in_ff, st_ff, id_ff;
   logic [3:0]  ws_in, cm_in, us_in, sy_in, fl_in, in_in, st_in, id_in;
   logic [4:0]  kw_ff, kw_in;
   logic [1:0]  bo_ff, bo_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] tb_ff, tb_in, off_ff, off_in, be_ff, be_in;
   logic [3:0]  best_ff, best_in;
   logic [1:0]  rc_ff, rc_in;
   logic        stop_ff, stop_in;
   logic [2:0]  qn_ff, qn_in;
   logic [7:0]  q_ff [4];
   logic [7:0]  q_in [4];
   logic [7:0]  r_ff [3];
   logic [7:0]  r_in [3];
   logic        rv_ff, rv_in;
   rsp_type     rd_ff, rd_in;

   // matcher outputs for the queue head
   logic [3:0]  f_ws, f_cm, f_us, f_sy, f_fl, f_in, f_st, f_id;
   logic [4:0]  f_kw;
   logic [1:0]  f_bo;
   logic [9:0]  acc;
   logic        alive;
   logic [3:0]  cls;
   logic [7:0]  c;
   logic [15:0] len_n;
   logic        out_free;
   logic        emit;
   rsp_type     emit_data;

   assign c     = q_ff[0];
   assign len_n = len_ff + 16'd1;

   always_comb begin
      acc  = '0;
      f_ws = ws_ff;
      if (ws_ff != DEAD) begin
         if (is_space(c)) begin
            f_ws = 4'd1;
            acc[C_WS] = 1'b1;
         end else begin
            f_ws = DEAD;
         end
      end

      f_cm = cm_ff;
      case (cm_ff)
         4'd0: f_cm = (c == 8'h2F) ? 4'd1 : DEAD;
         4'd1: begin
            if (c == 8'h2F) begin
               f_cm = 4'd2;
               acc[C_CM] = 1'b1;
            end else begin
               f_cm = DEAD;
            end
         end
         4'd2: begin
            if (c != 8'h0A) acc[C_CM] = 1'b1;
            else f_cm = DEAD;
         end
         default: f_cm = cm_ff;
      endcase

      f_kw = '0;
      for (int i = 0; i < 5; i++) begin
         if (kw_ff[i] && (len_ff < {13'd0, KW_LEN[i]}) &&
             (KW_TEXT[i][8*len_ff[2:0] +: 8] == c)) begin
            f_kw[i] = 1'b1;
            if (len_n == {13'd0, KW_LEN[i]}) acc[C_KW] = 1'b1;
         end
      end

      if ((us_ff == 4'd0) && (c == 8'h5F)) begin
         f_us = 4'd1;
         acc[C_US] = 1'b1;
      end else begin
         f_us = DEAD;
      end

      f_sy = DEAD;
      case (sy_ff) inside
         4'd0: begin
            if (is_single(c)) begin
               f_sy = 4'd1;
               acc[C_SY] = 1'b1;
            end else if (c == 8'h3A) begin
               f_sy = 4'd2;
               acc[C_SY] = 1'b1;
            end else if (c == 8'h3D) begin
               f_sy = 4'd3;
               acc[C_SY] = 1'b1;
            end else if (c == 8'h2D) begin
               f_sy = 4'd4;
            end
         end
         4'd2: begin
            if (c == 8'h3A) begin
               f_sy = 4'd1;
               acc[C_SY] = 1'b1;
            end
         end
         4'd3, 4'd4: begin
            if (c == 8'h3E) begin
               f_sy = 4'd1;
               acc[C_SY] = 1'b1;
            end
         end
         default: f_sy = DEAD;
      endcase

      f_fl = DEAD;
      case (fl_ff)
         4'd0: f_fl = (c == 8'h2D) ? 4'd1 : (is_digit(c) ? 4'd2 : DEAD);
         4'd1: f_fl = is_digit(c) ? 4'd2 : DEAD;
         4'd2: f_fl = is_digit(c) ? 4'd2 : ((c == 8'h2E) ? 4'd3 : DEAD);
         4'd3: begin
            if (is_digit(c)) begin
               f_fl = 4'd4;
               acc[C_FL] = 1'b1;
            end
         end
         4'd4: begin
            if (is_digit(c)) begin
               f_fl = 4'd4;
               acc[C_FL] = 1'b1;
            end else if (c == 8'h66) begin
               f_fl = 4'd5;
               acc[C_FL] = 1'b1;
            end
         end
         default: f_fl = DEAD;
      endcase

      f_in = DEAD;
      case (in_ff)
         4'd0: begin
            if (c == 8'h2D) begin
               f_in = 4'd1;
            end else if (is_digit(c)) begin
               f_in = 4'd2;
               acc[C_IN] = 1'b1;
            end
         end
         4'd1: begin
            if (is_digit(c)) begin
               f_in = 4'd2;
               acc[C_IN] = 1'b1;
            end
         end
         4'd2: begin
            if (is_digit(c)) begin
               f_in = 4'd2;
               acc[C_IN] = 1'b1;
            end else if ((c == 8'h69) || (c == 8'h75)) begin
               f_in = 4'd3;
            end
         end
         4'd3: begin
            if (c == 8'h38) begin
               f_in = 4'd8;
               acc[C_IN] = 1'b1;
            end else if (c == 8'h31) begin
               f_in = 4'd5;
            end else if (c == 8'h33) begin
               f_in = 4'd6;
            end else if (c == 8'h36) begin
               f_in = 4'd7;
            end
         end
         4'd5: begin
            if (c == 8'h36) begin
               f_in = 4'd8;
               acc[C_IN] = 1'b1;
            end
         end
         4'd6: begin
            if (c == 8'h32) begin
               f_in = 4'd8;
               acc[C_IN] = 1'b1;
            end
         end
         4'd7: begin
            if (c == 8'h34) begin
               f_in = 4'd8;
               acc[C_IN] = 1'b1;
            end
         end
         default: f_in = DEAD;
      endcase

      f_bo = '0;
      for (int i = 0; i < 2; i++) begin
         if (bo_ff[i] && (len_ff < {13'd0, BO_LEN[i]}) &&
             (BO_TEXT[i][8*len_ff[2:0] +: 8] == c)) begin
            f_bo[i] = 1'b1;
            if (len_n == {13'd0, BO_LEN[i]}) acc[C_BO] = 1'b1;
         end
      end

      f_st = DEAD;
      case (st_ff)
         4'd0: f_st = (c == 8'h22) ? 4'd1 : ((c == 8'h27) ? 4'd2 : DEAD);
         4'd1: begin
            f_st = 4'd1;
            if (c == 8'h22) begin
               f_st = 4'd3;
               acc[C_ST] = 1'b1;
            end
         end
         4'd2: begin
            f_st = 4'd2;
            if (c == 8'h27) begin
               f_st = 4'd3;
               acc[C_ST] = 1'b1;
            end
         end
         default: f_st = DEAD;
      endcase

      f_id = id_ff;
      case (id_ff)
         4'd0: begin
            if (is_alpha(c) || (c == 8'h5F)) begin
               f_id = 4'd1;
               acc[C_ID] = 1'b1;
            end else begin
               f_id = DEAD;
            end
         end
         4'd1: begin
            if (is_alpha(c) || is_digit(c) || (c == 8'h5F)) acc[C_ID] = 1'b1;
            else f_id = DEAD;
         end
         default: f_id = id_ff;
      endcase

      alive = (f_ws != DEAD) || (f_cm != DEAD) || (f_kw != '0) || (f_us != DEAD) ||
              (f_sy != DEAD) || (f_fl != DEAD) || (f_in != DEAD) || (f_bo != '0) ||
              (f_st != DEAD) || (f_id != DEAD);

      cls = NO_KIND;
      for (int i = 9; i >= 0; i--) begin
         if (acc[i]) cls = 4'(i);
      end
   end

   assign out_free = !rv_ff || !rsp_stall;

   always_comb begin
      ws_in = ws_ff;  cm_in = cm_ff;  kw_in = kw_ff;  us_in = us_ff;
      sy_in = sy_ff;  fl_in = fl_ff;  in_in = in_ff;  bo_in = bo_ff;
      st_in = st_ff;  id_in = id_ff;  len_in = len_ff;
      tb_in = tb_ff;  off_in = off_ff;  be_in = be_ff;  best_in = best_ff;
      rc_in = rc_ff;  stop_in = stop_ff;  qn_in = qn_ff;
      q_in = q_ff;
      r_in = r_ff;
      emit = 1'b0;
      emit_data.token_kind  = best_ff - C_KW;
      emit_data.token_start = tb_ff;
      emit_data.token_end   = be_ff;
      emit_data.last_result = 1'b0;

      if (cmd.load) begin
         qn_in = 3'd0;
         if (!stop_ff && (off_ff < POS_LIMIT)) begin
            q_in[0] = req_data.char_byte;
            qn_in   = 3'd1;
            off_in  = off_ff + 16'd1;
         end
      end

      if (cmd.step) begin
         if (alive) begin
            ws_in = f_ws;  cm_in = f_cm;  kw_in = f_kw;  us_in = f_us;
            sy_in = f_sy;  fl_in = f_fl;  in_in = f_in;  bo_in = f_bo;
            st_in = f_st;  id_in = f_id;  len_in = len_n;
            for (int j = 0; j < 3; j++) q_in[j] = q_ff[j+1];
            qn_in = qn_ff - 3'd1;
            if (cls != NO_KIND) begin
               best_in = cls;
               be_in   = tb_ff + len_n;
               rc_in   = 2'd0;
            end else if ((best_ff != NO_KIND) && (rc_ff != 2'd3)) begin
               r_in[rc_ff] = c;
               rc_in = rc_ff + 2'd1;
            end
         end else if (best_ff == NO_KIND) begin
            stop_in = 1'b1;
         end else begin
            emit = (best_ff >= C_KW);
            // replay bytes go ahead of the failing byte and what follows it
            case (rc_ff)
               2'd0: q_in = q_ff;
               2'd1: begin
                  q_in[0] = r_ff[0];
                  for (int j = 1; j < 4; j++) q_in[j] = q_ff[j-1];
               end
               2'd2: begin
                  q_in[0] = r_ff[0];  q_in[1] = r_ff[1];
                  q_in[2] = q_ff[0];  q_in[3] = q_ff[1];
               end
               default: begin
                  q_in[0] = r_ff[0];  q_in[1] = r_ff[1];
                  q_in[2] = r_ff[2];  q_in[3] = q_ff[0];
               end
            endcase
            qn_in = {1'b0, rc_ff} + qn_ff;
         end
      end

      if (cmd.fin_close) begin
         emit = (best_ff >= C_KW);
         for (int j = 0; j < 3; j++) q_in[j] = r_ff[j];
         qn_in = {1'b0, rc_ff};
      end

      // close the pending token at its best match
      if ((cmd.step && !alive && (best_ff != NO_KIND)) || cmd.fin_close) begin
         tb_in   = be_ff;
         ws_in = 4'd0;  cm_in = 4'd0;  kw_in = 5'h1F;  us_in = 4'd0;
         sy_in = 4'd0;  fl_in = 4'd0;  in_in = 4'd0;   bo_in = 2'h3;
         st_in = 4'd0;  id_in = 4'd0;  len_in = '0;
         best_in = NO_KIND;
         rc_in   = 2'd0;
      end

      if (cmd.set_stop) stop_in = 1'b1;

      if (cmd.emit_end) begin
         emit = 1'b1;
         emit_data.token_kind  = KIND_END;
         emit_data.token_start = tb_ff;
         emit_data.token_end   = tb_ff;
         emit_data.last_result = 1'b1;
         ws_in = 4'd0;  cm_in = 4'd0;  kw_in = 5'h1F;  us_in = 4'd0;
         sy_in = 4'd0;  fl_in = 4'd0;  in_in = 4'd0;   bo_in = 2'h3;
         st_in = 4'd0;  id_in = 4'd0;  len_in = '0;
         tb_in = '0;  off_in = '0;  be_in = '0;  best_in = NO_KIND;
         rc_in = 2'd0;  stop_in = 1'b0;  qn_in = 3'd0;
      end

      rd_in = rd_ff;
      rv_in = rv_ff;
      if (emit) begin
         rv_in = 1'b1;
         rd_in = emit_data;
      end else if (!rsp_stall) begin
         rv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff <= 4'd0;  cm_ff <= 4'd0;  kw_ff <= 5'h1F;  us_ff <= 4'd0;
         sy_ff <= 4'd0;  fl_ff <= 4'd0;  in_ff <= 4'd0;   bo_ff <= 2'h3;
         st_ff <= 4'd0;  id_ff <= 4'd0;  len_ff <= '0;
         tb_ff <= '0;  off_ff <= '0;  be_ff <= '0;  best_ff <= NO_KIND;
         rc_ff <= 2'd0;  stop_ff <= 1'b0;  qn_ff <= 3'd0;  rv_ff <= 1'b0;
      end else begin
         ws_ff <= ws_in;  cm_ff <= cm_in;  kw_ff <= kw_in;  us_ff <= us_in;
         sy_ff <= sy_in;  fl_ff <= fl_in;  in_ff <= in_in;  bo_ff <= bo_in;
         st_ff <= st_in;  id_ff <= id_in;  len_ff <= len_in;
         tb_ff <= tb_in;  off_ff <= off_in;  be_ff <= be_in;  best_ff <= best_in;
         rc_ff <= rc_in;  stop_ff <= stop_in;  qn_ff <= qn_in;  rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff  <= q_in;
      r_ff  <= r_in;
      rd_ff <= rd_in;
   end

   assign status.stopped   = stop_ff;
   assign status.at_limit  = (off_ff >= POS_LIMIT);
   assign status.q_empty   = (qn_ff == 3'd0);
   assign status.dead_best = !alive && (best_ff != NO_KIND);
   assign status.best_none = (best_ff == NO_KIND);
   assign status.len_zero  = (len_ff == 16'd0);
   assign status.out_free  = out_free;

   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;

endmodule

`default_nettype wire

// File: sv/lmt_ctrl.sv
// ----------------------------------------------------------------------------
// lmt_ctrl
// Sequencer: byte intake, queue walk, end-of-text closing, end transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module lmt_ctrl import lmt_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_last,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PROC = 4'b0010,
      ST_FIN  = 4'b0100,
      ST_END  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      fin_ff, fin_in;       // queue walk belongs to end-of-text closing
   logic      limit_ff, limit_in;   // closing caused by the length limit

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      fin_in   = fin_ff;
      limit_in = limit_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               last_in  = req_last;
               fin_in   = 1'b0;
               limit_in = 1'b0;
               if (!status.stopped && status.at_limit) begin
                  limit_in = 1'b1;
                  fin_in   = 1'b1;
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_PROC;
               end
            end
         end
         ST_PROC: begin
            if (status.stopped || status.q_empty) begin
               if (fin_ff || last_ff) begin
                  fin_in   = 1'b1;
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (!status.dead_best || status.out_free) begin
               cmd.step = 1'b1;
            end
         end
         ST_FIN: begin
            if (status.stopped || status.len_zero) begin
               if (limit_ff) begin
                  cmd.set_stop = 1'b1;
                  state_in = last_ff ? ST_END : ST_IDLE;
               end else begin
                  state_in = ST_END;
               end
            end else if (status.best_none) begin
               cmd.set_stop = 1'b1;
            end else if (status.out_free) begin
               cmd.fin_close = 1'b1;
               state_in = ST_PROC;
            end
         end
         ST_END: begin
            if (status.out_free) begin
               cmd.emit_end = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
         fin_ff   <= 1'b0;
         limit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
         fin_ff   <= fin_in;
         limit_ff <= limit_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/longest_match_tokenizer.sv
// ----------------------------------------------------------------------------
// longest_match_tokenizer
// Byte-stream tokenizer, longest match over ten token classes.
// ----------------------------------------------------------------------------
// Each byte transaction is accepted, every queued byte is fed to the class
// matchers and the queue is then seen empty. When every matcher fails, the
// token is closed at its best match in the same cycle and up to three bytes
// read past it are replayed, ahead of the failing byte, from a four-entry
// queue, one matcher step per cycle while no closing step waits on a held
// result register. The final byte adds a closing walk over the replayed bytes
// (a closing step, one matcher step per byte and a check for an empty queue,
// per pending token), then a check that nothing is pending and the end
// transaction. A token transaction or the end transaction waits while the
// result register is held by a stall. Whitespace and comments produce no
// transaction; an unmatched byte stops the scan until the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_match_tokenizer import lmt_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   // byte transactions
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   // token transactions
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   cmd_type    cmd;
   status_type status;

   // sequencer: owns the input handshake
   lmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_last  (req_data.last_byte),
      .status    (status),
      .cmd       (cmd)
   );

   // matchers, replay queue and result register
   lmt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: tb/longest_match_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// longest_match_tokenizer_tb
// Self-checking bench for the byte-stream longest-match tokenizer.
// ----------------------------------------------------------------------------
// Byte transactions go in through a table of directed texts, then random texts
// built from token fragments, separators and noise. A local scanner predicts
// every token transaction; each result is checked field by field against the
// oldest expected token. Sender idling and receiver stalls change by phase.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_match_tokenizer_tb;
   import lmt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [7:0] NONE_CLS = 8'hFF;

   // token kinds as driven on rsp_data
   typedef enum logic [3:0] {
      TK_KEYWORD = 4'd0, TK_UNDERSCORE = 4'd1, TK_SYMBOL = 4'd2, TK_FLOAT = 4'd3,
      TK_INT = 4'd4, TK_BOOL = 4'd5, TK_STRING = 4'd6, TK_IDENT = 4'd7,
      TK_END = 4'd8
   } token_kind_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   longest_match_tokenizer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Token predictor: per-class matcher states plus the pending-token record
   // ------------------------------------------------------------------------
   logic [7:0]  m_ws, m_cm, m_kw, m_us, m_sy, m_fl, m_in, m_bo, m_st, m_id;
   int unsigned m_len;
   int unsigned tok_begin, text_pos, best_stop;
   logic [7:0]  best_cls;
   logic [7:0]  held [3];
   int unsigned held_cnt;
   bit          halted;

   rsp_type expected_tokens[$];
   int          err_count;
   int          bytes_sent, tokens_seen;

   string kw_words[5] = '{"let", "fn", "if", "else", "mod"};
   string bo_words[2] = '{"true", "false"};

   function automatic bit dig(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic bit alp(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic void matchers_clear();
      {m_ws, m_cm, m_us, m_sy, m_fl, m_in, m_st, m_id} = '0;
      m_kw  = 8'h1F;
      m_bo  = 8'h03;
      m_len = 0;
   endfunction

   function automatic void scanner_reset();
      matchers_clear();
      tok_begin = 0;
      text_pos  = 0;
      best_stop = 0;
      best_cls  = NONE_CLS;
      held_cnt  = 0;
      halted    = 0;
   endfunction

   // word-list matcher for keywords and bools
   function automatic logic [7:0] word_match(logic [7:0] mask, string w[], int unsigned p,
                                             logic [7:0] c, inout bit hit);
      logic [7:0] keep;
      keep = '0;
      for (int i = 0; i < w.size(); i++)
         if (mask[i] && p < w[i].len() && w[i][p] == c) begin
            keep[i] = 1'b1;
            if (p + 1 == w[i].len()) hit = 1;
         end
      return keep;
   endfunction

   // one byte into all matchers; returns 1 while some class can still match
   function automatic bit matchers_feed(logic [7:0] c, output logic [7:0] cls);
      logic [9:0] acc;
      bit hit;
      acc = '0;
      if (m_ws != 8'hFF) begin
         if (c == " " || (c >= 9 && c <= 13)) begin m_ws = 1; acc[0] = 1; end
         else m_ws = 8'hFF;
      end
      case (m_cm)
         0: m_cm = (c == "/") ? 8'd1 : 8'hFF;
         1: if (c == "/") begin m_cm = 2; acc[1] = 1; end else m_cm = 8'hFF;
         2: if (c != 8'h0A) acc[1] = 1; else m_cm = 8'hFF;
         default: ;
      endcase
      hit = 0;
      m_kw = word_match(m_kw, kw_words, m_len, c, hit);
      acc[2] = hit;
      if (m_us == 0 && c == "_") begin m_us = 1; acc[3] = 1; end else m_us = 8'hFF;
      case (m_sy) inside
         0: begin
            if (c inside {"(", ")", "{", "}", ",", ".", "&", ";"}) begin
               m_sy = 1; acc[4] = 1;
            end else if (c == ":") begin m_sy = 2; acc[4] = 1; end
            else if (c == "=") begin m_sy = 3; acc[4] = 1; end
            else if (c == "-") m_sy = 4;
            else m_sy = 8'hFF;
         end
         2: if (c == ":") begin m_sy = 1; acc[4] = 1; end else m_sy = 8'hFF;
         3, 4: if (c == ">") begin m_sy = 1; acc[4] = 1; end else m_sy = 8'hFF;
         default: m_sy = 8'hFF;
      endcase
      case (m_fl)
         0: m_fl = (c == "-") ? 8'd1 : (dig(c) ? 8'd2 : 8'hFF);
         1: m_fl = dig(c) ? 8'd2 : 8'hFF;
         2: m_fl = dig(c) ? 8'd2 : (c == "." ? 8'd3 : 8'hFF);
         3: if (dig(c)) begin m_fl = 4; acc[5] = 1; end else m_fl = 8'hFF;
         4: begin
            if (dig(c)) acc[5] = 1;
            else if (c == "f") begin m_fl = 5; acc[5] = 1; end
            else m_fl = 8'hFF;
         end
         default: m_fl = 8'hFF;
      endcase
      case (m_in)
         0: begin
            if (c == "-") m_in = 1;
            else if (dig(c)) begin m_in = 2; acc[6] = 1; end
            else m_in = 8'hFF;
         end
         1: if (dig(c)) begin m_in = 2; acc[6] = 1; end else m_in = 8'hFF;
         2: begin
            if (dig(c)) acc[6] = 1;
            else if (c == "i" || c == "u") m_in = 3;
            else m_in = 8'hFF;
         end
         3: begin
            if (c == "8") begin m_in = 8; acc[6] = 1; end
            else if (c == "1") m_in = 5;
            else if (c == "3") m_in = 6;
            else if (c == "6") m_in = 7;
            else m_in = 8'hFF;
         end
         5: if (c == "6") begin m_in = 8; acc[6] = 1; end else m_in = 8'hFF;
         6: if (c == "2") begin m_in = 8; acc[6] = 1; end else m_in = 8'hFF;
         7: if (c == "4") begin m_in = 8; acc[6] = 1; end else m_in = 8'hFF;
         default: m_in = 8'hFF;
      endcase
      hit = 0;
      m_bo = word_match(m_bo, bo_words, m_len, c, hit);
      acc[7] = hit;
      case (m_st)
         0: m_st = (c == 8'h22) ? 8'd1 : (c == 8'h27 ? 8'd2 : 8'hFF);
         1: if (c == 8'h22) begin m_st = 3; acc[8] = 1; end
         2: if (c == 8'h27) begin m_st = 3; acc[8] = 1; end
         default: m_st = 8'hFF;
      endcase
      case (m_id)
         0: if (alp(c) || c == "_") begin m_id = 1; acc[9] = 1; end else m_id = 8'hFF;
         1: if (alp(c) || dig(c) || c == "_") acc[9] = 1; else m_id = 8'hFF;
         default: ;
      endcase
      m_len++;
      cls = NONE_CLS;
      for (int i = 9; i >= 0; i--) if (acc[i]) cls = 8'(i);
      return m_ws != 8'hFF || m_cm != 8'hFF || m_kw != 0 || m_us != 8'hFF ||
             m_sy != 8'hFF || m_fl != 8'hFF || m_in != 8'hFF || m_bo != 0 ||
             m_st != 8'hFF || m_id != 8'hFF;
   endfunction

   function automatic void push_token(logic [3:0] kind, int unsigned s, int unsigned e,
                                      logic last);
      rsp_type t;
      t.token_kind  = kind;
      t.token_start = 16'(s);
      t.token_end   = 16'(e);
      t.last_result = last;
      expected_tokens = {expected_tokens, t};
   endfunction

   // whitespace and comments are swallowed; everything else shifts down by 2
   function automatic void token_close();
      if (best_cls >= 2 && best_cls <= 9)
         push_token(4'(best_cls - 2), tok_begin, best_stop, 1'b0);
      tok_begin = best_stop;
      matchers_clear();
      best_cls = NONE_CLS;
      held_cnt = 0;
   endfunction

   function automatic void scan_bytes(logic [7:0] src[$]);
      logic [7:0] q[$], nq[$];
      logic [7:0] c, cls;
      q = src;
      while (q.size() > 0) begin
         if (halted) return;
         c = q.pop_front();
         if (!matchers_feed(c, cls)) begin
            if (best_cls == NONE_CLS) begin halted = 1; return; end
            nq = {};
            for (int j = 0; j < held_cnt; j++) nq = {nq, held[j]};
            nq = {nq, c};
            q = {nq, q};
            token_close();
            continue;
         end
         if (cls != NONE_CLS) begin
            best_cls  = cls;
            best_stop = tok_begin + m_len;
            held_cnt  = 0;
         end else if (best_cls != NONE_CLS && held_cnt < 3) begin
            held[held_cnt] = c;
            held_cnt++;
         end
      end
   endfunction

   function automatic void text_close();
      logic [7:0] rest[$];
      while (!halted && m_len != 0) begin
         if (best_cls == NONE_CLS) begin halted = 1; break; end
         rest = {};
         for (int j = 0; j < held_cnt; j++) rest = {rest, held[j]};
         token_close();
         scan_bytes(rest);
      end
   endfunction

   function automatic void predict_byte(req_type r);
      if (!halted) begin
         if (text_pos >= int'(POS_LIMIT)) begin
            text_close();
            halted = 1;
         end else begin
            scan_bytes('{r.char_byte});
            text_pos++;
         end
      end
      if (r.last_byte) begin
         text_close();
         push_token(TK_END, tok_begin, tok_begin, 1'b1);
         scanner_reset();
      end
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(string what, rsp_type got, rsp_type want);
      $display("MISMATCH %s: got kind %0d [%0d,%0d) last %0b, want kind %0d [%0d,%0d) last %0b",
               what, got.token_kind, got.token_start, got.token_end, got.last_result,
               want.token_kind, want.token_start, want.token_end, want.last_result);
      err_count++;
   endtask

   int idle_cycles;

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            tokens_seen++;
            idle_cycles <= 0;
            if (expected_tokens.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_data, '0);
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_data !== want) report_mismatch("token", rsp_data, want);
            end
         end else if (req_valid && !req_stall) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Idling control
   // ------------------------------------------------------------------------
   int send_idle_pct, recv_stall_pct;

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // one byte transaction; predicted at acceptance time. Valid stays up after
   // acceptance until the next call idles or replaces the byte.
   task automatic send_byte(logic [7:0] c, logic last);
      req_type r;
      r.char_byte = c;
      r.last_byte = last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_byte(r);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   // directed texts; the expected tokens of the first rows are typed in
   typedef struct {
      string      text;
      int         n_tok;
      rsp_type    tok[3];
   } text_row_type;

   text_row_type directed[$];

   function automatic rsp_type mk(logic [3:0] k, int s, int e, logic l);
      mk = '{token_kind: k, token_start: 16'(s), token_end: 16'(e), last_result: l};
   endfunction

   function automatic void build_table();
      directed = '{
         '{"x", 2, '{mk(TK_IDENT, 0, 1, 0), mk(TK_END, 1, 1, 1), '0}},
         '{"let", 2, '{mk(TK_KEYWORD, 0, 3, 0), mk(TK_END, 3, 3, 1), '0}},
         '{"_", 2, '{mk(TK_UNDERSCORE, 0, 1, 0), mk(TK_END, 1, 1, 1), '0}},
         '{"#", 1, '{mk(TK_END, 0, 0, 1), '0, '0}},
         '{"  ", 1, '{mk(TK_END, 2, 2, 1), '0, '0}},
         '{"\"ab", 1, '{mk(TK_END, 0, 0, 1), '0, '0}},
         '{"12.x", 0, '{'0, '0, '0}},
         '{"1i6x", 0, '{'0, '0, '0}},
         '{"-12.5f fn if else mod", 0, '{'0, '0, '0}},
         '{"true false falsey", 0, '{'0, '0, '0}},
         '{"(){},.::&->=>=;:", 0, '{'0, '0, '0}},
         '{"7u64 3i32 9u8 -4i16", 0, '{'0, '0, '0}},
         '{"// note\nab_9 'q' \"s\"", 0, '{'0, '0, '0}},
         '{"ab @ cd", 0, '{'0, '0, '0}},
         '{"-x", 0, '{'0, '0, '0}}
      };
   endfunction

   // random text built mostly from valid fragments
   function automatic string random_text();
      string s, frag;
      int n;
      s = "";
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(11))
            0: frag = kw_words[$urandom_range(4)];
            1: frag = bo_words[$urandom_range(1)];
            2: frag = $sformatf("%s%0d", $urandom_range(1) ? "-" : "", $urandom_range(999));
            3: frag = $sformatf("%0d.%0d%s", $urandom_range(99), $urandom_range(99),
                                $urandom_range(1) ? "f" : "");
            4: frag = $sformatf("%0d%s", $urandom_range(99),
                                $urandom_range(1) ? "i16" : "u8");
            5: frag = $sformatf("v%0d_%c", $urandom_range(99), "a" + $urandom_range(25));
            6: frag = $urandom_range(1) ? "::" : "->";
            7: frag = $urandom_range(1) ? "\"a b\"" : "'z'";
            8: frag = "// c\n";
            9: frag = $sformatf("%0d.%c", $urandom_range(9), "x");
            10: begin
               frag = " ";
               frag[0] = 8'($urandom_range(255));
            end
            default: frag = "_";
         endcase
         s = {s, frag, ($urandom_range(3) == 0) ? "" : " "};
      end
      return s;
   endfunction

   task automatic drain();
      int guard;
      guard = 0;
      while (expected_tokens.size() != 0 && guard < 20 * WATCHDOG_LIMIT) begin
         @(posedge clock);
         guard++;
      end
   endtask

   initial begin
      string s;
      err_count = 0;
      bytes_sent = 0;
      tokens_seen = 0;
      idle_cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      scanner_reset();
      build_table();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, no idling
      foreach (directed[i]) begin
         send_text(directed[i].text);
         if (directed[i].n_tok > 0) begin
            if (expected_tokens.size() != directed[i].n_tok) begin
               $display("MISMATCH row %0d: predicted %0d tokens, table has %0d",
                        i, expected_tokens.size(), directed[i].n_tok);
               err_count++;
            end
            for (int k = 0; k < directed[i].n_tok && k < expected_tokens.size(); k++)
               if (expected_tokens[k] !== directed[i].tok[k]) begin
                  $display("MISMATCH row %0d token %0d: predictor disagrees with table", i, k);
                  err_count++;
               end
         end
      end

      // random texts over four idling phases
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         for (int b = 0; b < 20;) begin
            s = random_text();
            send_text(s);
            b += s.len();
         end
      end
      req_valid <= 1'b0;

      drain();
      repeat (30) @(posedge clock);
      $display("covered %0d bytes, %0d token transactions, directed and four idling phases",
               bytes_sent, tokens_seen);
      if (err_count == 0 && expected_tokens.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d tokens never seen", err_count, expected_tokens.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
sv/lmt_pkg.sv
sv/lmt_datapath.sv
sv/lmt_ctrl.sv
sv/longest_match_tokenizer.sv
tb/longest_match_tokenizer_tb.sv
